>>> design/lesf_pkg.sv
// Package for the largest empty square finder.
// Holds field widths, grid limits and register indexes; depends on nothing.
`default_nettype none

package lesf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SIDE_W    = COL_W + 1;
    localparam int ROW_W     = 16;
    localparam int GW_W      = 11;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic EMPTY_CODE = 1'b1;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [SIDE_W-1:0] t_side;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = GW_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = ROW_W'(1);

endpackage

`default_nettype wire

>>> design/largest_empty_square_finder_top.sv
// Largest empty square finder: maximal-square recurrence over a raster tile stream.
// Uses lesf_pkg; holds the previous row's sizes in one on-chip memory.
`default_nettype none

//  channel  | direction | handshake                      | words
//  ---------+-----------+--------------------------------+------------------------------
//  tile     | in        | i_tile_valid / o_tile_ready    | i_tile_is_empty
//  result   | out       | o_res_valid / i_res_ready      | o_best_column/_row/_side
//  config   | in        | i_cfg_we (no wait, no readback)| i_cfg_idx, i_cfg_data
//
//  One tile word per cycle sustained. A result word turns valid when the last tile
//  of the grid leaves the compute stage as a result. The rate is set by the row-size
//  memory: one read (issued at accept) and one write (in the compute stage) per
//  tile, with the written size forwarded when the next tile reads the same column.
//  Reset is synchronous; the row-size memory needs no clearing pass. The tile side
//  stalls only when a finished result still sits unclaimed in the output register.

module largest_empty_square_finder_top
    import lesf_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_tile_valid,
    output logic                 o_tile_ready,
    input  wire                  i_tile_is_empty,
    output logic                 o_res_valid,
    input  wire                  i_res_ready,
    output logic [COL_W-1:0]     o_best_column,
    output logic [ROW_W-1:0]     o_best_row,
    output logic [SIDE_W-1:0]    o_best_side,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [GW_W-1:0]  r_grid_width;
    logic [ROW_W-1:0] r_grid_height;
    logic [GW_W-1:0]  w_eff;
    logic [ROW_W-1:0] h_eff;

    // position counters (front stage)
    t_col r_col, n_col;
    t_row r_row, n_row;
    logic accept, row_end, grid_end;

    // compute stage
    logic  r_s1_vld;
    t_col  r_s1_col;
    t_row  r_s1_row;
    logic  r_s1_empty;
    logic  r_s1_last;
    logic  r_s1_fwd;
    t_side r_s1_fwd_data;
    logic  s1_go;

    // row-size memory
    t_side r_upper_mem [MAX_WIDTH];
    t_side r_rdata;

    // recurrence
    t_side r_left, r_diag;
    t_side up, left, diag, m3, m_plus;
    logic [ROW_W:0] row_lim;
    t_side col_lim;
    t_side size;

    // best so far
    t_side r_best_side, n_best_side;
    t_col  r_best_col,  n_best_col;
    t_row  r_best_row,  n_best_row;

    // output register
    logic  r_out_vld;
    t_col  r_out_col;
    t_row  r_out_row;
    t_side r_out_side;

    // ---------------------------------------------------------------------
    // Effective grid size: zero acts as one, width clamps at MAX_WIDTH.
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = GW_W'(1);
        end else if (r_grid_width > GW_W'(MAX_WIDTH)) begin
            w_eff = GW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_grid_width;
        end
        h_eff = (r_grid_height == '0) ? ROW_W'(1) : r_grid_height;
    end

    // Compute stage advances unless it holds a last tile and the output is full.
    assign s1_go        = r_s1_vld && (!r_s1_last || !r_out_vld || i_res_ready);
    assign o_tile_ready = !r_s1_vld || s1_go;
    assign accept       = i_tile_valid && o_tile_ready;

    always_comb begin
        row_end  = ({1'b0, r_col} + GW_W'(1)) >= w_eff;
        grid_end = row_end && (({1'b0, r_row} + (ROW_W+1)'(1)) >= {1'b0, h_eff});
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (grid_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Recurrence: min(up, left, diag) + 1, capped by row and column position.
    // Neighbors off the grid edge count as zero.
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_s1_row == '0) begin
            up = '0;
        end else begin
            up = r_s1_fwd ? r_s1_fwd_data : r_rdata;
        end
        left = (r_s1_col == '0) ? '0 : r_left;
        diag = (r_s1_col == '0 || r_s1_row == '0) ? '0 : r_diag;

        m3 = (up < left) ? up : left;
        m3 = (diag < m3) ? diag : m3;
        m_plus  = m3 + SIDE_W'(1);
        row_lim = {1'b0, r_s1_row} + (ROW_W+1)'(1);
        col_lim = {1'b0, r_s1_col} + SIDE_W'(1);

        if (r_s1_empty == EMPTY_CODE) begin
            size = m_plus;
            if ((ROW_W+1)'(size) > row_lim) begin
                size = SIDE_W'(row_lim);
            end
            if (size > col_lim) begin
                size = col_lim;
            end
        end else begin
            size = '0;
        end

        n_best_side = r_best_side;
        n_best_col  = r_best_col;
        n_best_row  = r_best_row;
        if (size > r_best_side) begin
            n_best_side = size;
            n_best_col  = COL_W'(col_lim - size);
            n_best_row  = ROW_W'(row_lim - (ROW_W+1)'(size));
        end
    end

    // ---------------------------------------------------------------------
    // Row-size memory: read at accept, write back from the compute stage.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_upper_mem[r_col];
        end
        if (s1_go) begin
            r_upper_mem[r_s1_col] <= size;
        end
    end

    // Compute stage payload; forward the size being written to the same column.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_empty    <= i_tile_is_empty;
            r_s1_last     <= grid_end;
            r_s1_fwd      <= s1_go && (r_s1_col == r_col);
            r_s1_fwd_data <= size;
        end
        if (s1_go && r_s1_last) begin
            r_out_col  <= n_best_col;
            r_out_row  <= n_best_row;
            r_out_side <= n_best_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_col         <= '0;
            r_row         <= '0;
            r_s1_vld      <= 1'b0;
            r_left        <= '0;
            r_diag        <= '0;
            r_best_side   <= '0;
            r_best_col    <= '0;
            r_best_row    <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GW_W-1:0];
                    REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_left <= size;
                r_diag <= up;
                if (r_s1_last) begin
                    r_best_side <= '0;
                    r_best_col  <= '0;
                    r_best_row  <= '0;
                end else begin
                    r_best_side <= n_best_side;
                    r_best_col  <= n_best_col;
                    r_best_row  <= n_best_row;
                end
            end
            if (s1_go && r_s1_last) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_out_vld;
    assign o_best_column = r_out_col;
    assign o_best_row    = r_out_row;
    assign o_best_side   = r_out_side;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_tile_ready |-> (r_s1_vld && r_s1_last && r_out_vld))
        else $error("tile side stalled without a pending result");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted tile did not reach compute stage");

    a_zero_side_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_side == '0) |-> (r_best_col == '0 && r_best_row == '0))
        else $error("empty best carries a nonzero corner");

    a_side_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_side <= SIDE_W'(MAX_WIDTH))
        else $error("best side exceeds grid width limit");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_last) |=> o_res_valid)
        else $error("last tile did not raise a result");

endmodule

`default_nettype wire
